// ===== sv/gfcf_pkg.sv =====
package gfcf_pkg;

    // request kind carried on tuser
    typedef enum logic {
        KIND_MUL = 1'b0,
        KIND_INV = 1'b1
    } kind_t;

    typedef logic [3:0] nib_t;
    typedef logic [7:0] byte_t;

    // constant v of the extension y^2 = y + v
    localparam nib_t GF16_V = 4'he;

    // rows of the basis change into the composite field
    localparam byte_t TO_COMP [8] = '{
        8'h71, 8'h06, 8'h82, 8'h14, 8'h70, 8'hd2, 8'hac, 8'ha0
    };

    // rows of the basis change back to the polynomial basis
    localparam byte_t FROM_COMP [8] = '{
        8'h11, 8'hb0, 8'hb2, 8'h72, 8'hba, 8'h34, 8'h9e, 8'hb4
    };

    // GF(2^4) inverse, zero maps to zero
    localparam nib_t GF16_INV [16] = '{
        4'h0, 4'h1, 4'h9, 4'he, 4'hd, 4'hb, 4'h7, 4'h6,
        4'hf, 4'h2, 4'hc, 4'h5, 4'ha, 4'h4, 4'h3, 4'h8
    };

    // bit i of the result is the parity of row i and x
    function automatic byte_t apply_matrix(input byte_t rows [8], input byte_t x);
        byte_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[i] = ^(rows[i] & x);
        end
        return r;
    endfunction

    // multiply by x modulo x^4+x+1
    function automatic nib_t nib_xtime(input nib_t a);
        nib_t r;
        r = {a[2:0], 1'b0};
        if (a[3]) begin
            r = r ^ 4'h3;
        end
        return r;
    endfunction

    // GF(2^4) multiply, shift and add over four bits
    function automatic nib_t nib_mul(input nib_t a, input nib_t b);
        nib_t r;
        nib_t s;
        r = '0;
        s = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
                r = r ^ s;
            end
            s = nib_xtime(s);
        end
        return r;
    endfunction

    // GF(2^4) squaring is linear
    function automatic nib_t nib_square(input nib_t a);
        return {a[3], a[1] ^ a[3], a[2], a[0] ^ a[2]};
    endfunction

endpackage

// ===== sv/gf256_composite_field_mul_inv_top.sv =====
// GF(2^8) multiply or inverse over the composite field GF((2^4)^2). Each request
// carries a kind on s_tuser (0 multiply operand_a by operand_b, 1 invert operand_a;
// operand_b is then ignored, and zero inverts to zero). The datapath is a four-stage
// pipeline: basis change in, GF(2^4) products and norm, recombination with the
// inverse table, basis change out. A request moves through stages 1 to 3 into the
// output register; one is taken every cycle unless a stall reaches stage 1. The
// output register holds a result until m_tready, while empty stages in front of it
// keep filling. No state is kept between requests; reset only empties the pipeline.
module gf256_composite_field_mul_inv_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] operand_a, [15:8] operand_b
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] product_or_inverse
);

    localparam int NUM_STAGES = 4;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    // stage 1 payload: composite operands
    gfcf_pkg::kind_t   s1_kind_reg;
    gfcf_pkg::byte_t   s1_g_reg;
    gfcf_pkg::byte_t   s1_h_reg;

    // stage 2 payload: nibble products and norm
    gfcf_pkg::kind_t   s2_kind_reg;
    gfcf_pkg::nib_t    s2_gh_reg;
    gfcf_pkg::nib_t    s2_gl_reg;
    gfcf_pkg::nib_t    s2_phh_reg;
    gfcf_pkg::nib_t    s2_pcross_reg;
    gfcf_pkg::nib_t    s2_pll_reg;
    gfcf_pkg::nib_t    s2_norm_reg;

    // stage 3 payload: composite result
    gfcf_pkg::byte_t   s3_res_reg;

    // stage 4 payload: output byte
    gfcf_pkg::byte_t   s4_out_reg;

    gfcf_pkg::nib_t    s1_gh;
    gfcf_pkg::nib_t    s1_gl;
    gfcf_pkg::nib_t    s1_hh;
    gfcf_pkg::nib_t    s1_hl;
    gfcf_pkg::nib_t    s3_hi;
    gfcf_pkg::nib_t    s3_lo;
    gfcf_pkg::nib_t    s3_ni;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb begin
        valid_next[0] = load[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = load[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = s4_out_reg;

    // stage 1: basis change of both operands
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            s1_kind_reg <= gfcf_pkg::kind_t'(s_tuser);
            s1_g_reg    <= gfcf_pkg::apply_matrix(gfcf_pkg::TO_COMP, s_tdata[7:0]);
            s1_h_reg    <= gfcf_pkg::apply_matrix(gfcf_pkg::TO_COMP, s_tdata[15:8]);
        end
    end

    assign s1_gh = s1_g_reg[7:4];
    assign s1_gl = s1_g_reg[3:0];
    assign s1_hh = s1_h_reg[7:4];
    assign s1_hl = s1_h_reg[3:0];

    // stage 2: subfield products, norm for inversion
    always_ff @(posedge aclk) begin
        if (load[1]) begin
            s2_kind_reg   <= s1_kind_reg;
            s2_gh_reg     <= s1_gh;
            s2_gl_reg     <= s1_gl;
            s2_phh_reg    <= gfcf_pkg::nib_mul(s1_gh, s1_hh);
            s2_pcross_reg <= gfcf_pkg::nib_mul(s1_gh, s1_hl)
                           ^ gfcf_pkg::nib_mul(s1_gl, s1_hh);
            s2_pll_reg    <= gfcf_pkg::nib_mul(s1_gl, s1_hl);
            s2_norm_reg   <= gfcf_pkg::nib_mul(gfcf_pkg::nib_square(s1_gh), gfcf_pkg::GF16_V)
                           ^ gfcf_pkg::nib_mul(s1_gh, s1_gl)
                           ^ gfcf_pkg::nib_square(s1_gl);
        end
    end

    // stage 3: recombine product, or norm inverse times conjugate
    always_comb begin
        s3_ni = gfcf_pkg::GF16_INV[s2_norm_reg];
        unique case (s2_kind_reg)
            gfcf_pkg::KIND_MUL: begin
                s3_hi = s2_pcross_reg ^ s2_phh_reg;
                s3_lo = s2_pll_reg ^ gfcf_pkg::nib_mul(s2_phh_reg, gfcf_pkg::GF16_V);
            end
            gfcf_pkg::KIND_INV: begin
                s3_hi = gfcf_pkg::nib_mul(s2_gh_reg, s3_ni);
                s3_lo = gfcf_pkg::nib_mul(s2_gh_reg ^ s2_gl_reg, s3_ni);
            end
            default: begin
                s3_hi = '0;
                s3_lo = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            s3_res_reg <= {s3_hi, s3_lo};
        end
    end

    // stage 4: back to the polynomial basis
    always_ff @(posedge aclk) begin
        if (load[3]) begin
            s4_out_reg <= gfcf_pkg::apply_matrix(gfcf_pkg::FROM_COMP, s3_res_reg);
        end
    end

`ifndef SYNTHESIS
    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted request not captured in stage 1");

    // a full pipeline with a stalled output takes no request
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_tready |-> !s_tready)
        else $error("request taken while pipeline full and stalled");

    // a held item in stage 3 is not dropped while the output stalls
    a_stage3_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[2] && !load[3] |=> valid_reg[2])
        else $error("stage 3 item lost during stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> valid_reg == '0)
        else $error("pipeline not empty after reset");
`endif

endmodule
